FILE: design/atpr_pkg.sv
// Shared constants, payload types and the arctangent table for the tilt block.
// Used by the square root cell, the rotation cell and the top level.
`default_nettype none

package atpr_pkg;

   localparam int AXIS_W = 16;
   localparam int PITCH_W = 15;
   localparam int ROLL_W = 16;

   localparam int CORDIC_STAGES = 16;
   localparam int TABLE_SIZE = 24;
   localparam int CORDIC_CELLS = (CORDIC_STAGES > TABLE_SIZE) ? TABLE_SIZE : CORDIC_STAGES;
   localparam int STAGE_W = 5;

   localparam int SQ_W = 2 * AXIS_W;
   localparam int ROOT_W = 30;
   localparam int REM_W = ROOT_W + 2;
   localparam int SQ_WORK_W = REM_W + 2;
   localparam int SQRT_CELLS = ROOT_W;

   localparam int GUARD_SHIFT = 14;
   localparam int VEC_W = 34;
   localparam int ACC_W = 26;
   localparam int ROUND_SHIFT = 9;
   localparam int RES_W = ACC_W + 1 - ROUND_SHIFT;

   localparam logic signed [ACC_W-1:0] ANGLE_180 = ACC_W'(11796480);
   localparam logic signed [ACC_W:0] ROUND_BIAS = (ACC_W + 1)'(256);
   localparam logic signed [RES_W-1:0] PITCH_LIMIT = RES_W'(11520);
   localparam logic signed [RES_W-1:0] ROLL_LIMIT = RES_W'(23040);

   typedef struct packed {
      logic [SQ_W-1:0] radicand;
      logic [REM_W-1:0] rem;
      logic [ROOT_W-1:0] root;
      logic signed [AXIS_W-1:0] accel_x;
      logic signed [AXIS_W-1:0] accel_y;
      logic signed [AXIS_W-1:0] accel_z;
   } sqrt_type;

   typedef struct packed {
      logic signed [VEC_W-1:0] vx;
      logic signed [VEC_W-1:0] vy;
      logic signed [ACC_W-1:0] acc;
      logic zero;
   } rot_type;

   typedef struct packed {
      rot_type pitch;
      rot_type roll;
   } cordic_type;

   // Entry i is atan(2^-i) in degrees scaled by 65536, rounded to nearest.
   function automatic logic signed [ACC_W-1:0] atan_entry(input logic [STAGE_W-1:0] idx);
      logic signed [ACC_W-1:0] angle;
      unique case (idx)
         5'd0: angle = ACC_W'(2949120);
         5'd1: angle = ACC_W'(1740967);
         5'd2: angle = ACC_W'(919879);
         5'd3: angle = ACC_W'(466945);
         5'd4: angle = ACC_W'(234379);
         5'd5: angle = ACC_W'(117304);
         5'd6: angle = ACC_W'(58666);
         5'd7: angle = ACC_W'(29335);
         5'd8: angle = ACC_W'(14668);
         5'd9: angle = ACC_W'(7334);
         5'd10: angle = ACC_W'(3667);
         5'd11: angle = ACC_W'(1833);
         5'd12: angle = ACC_W'(917);
         5'd13: angle = ACC_W'(458);
         5'd14: angle = ACC_W'(229);
         5'd15: angle = ACC_W'(115);
         5'd16: angle = ACC_W'(57);
         5'd17: angle = ACC_W'(29);
         5'd18: angle = ACC_W'(14);
         5'd19: angle = ACC_W'(7);
         5'd20: angle = ACC_W'(4);
         5'd21: angle = ACC_W'(2);
         5'd22: angle = ACC_W'(1);
         default: angle = '0;
      endcase
      return angle;
   endfunction

endpackage

`default_nettype wire

FILE: design/atpr_sqrt_cell.sv
// One result bit of the restoring integer square root, registered.
// Depends on atpr_pkg for the payload type and widths.
`default_nettype none

module atpr_sqrt_cell (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                advance,
   input  wire logic                in_valid,
   input  wire atpr_pkg::sqrt_type  in_data,
   output      logic                out_valid,
   output      atpr_pkg::sqrt_type  out_data
);

   logic valid_ff;
   atpr_pkg::sqrt_type data_ff;
   atpr_pkg::sqrt_type data_in;
   logic [atpr_pkg::SQ_WORK_W-1:0] rem_shifted;
   logic [atpr_pkg::SQ_WORK_W-1:0] trial;

   always_comb begin
      data_in = in_data;
      rem_shifted = {in_data.rem, in_data.radicand[atpr_pkg::SQ_W-1 -: 2]};
      trial = atpr_pkg::SQ_WORK_W'({in_data.root, 2'b01});
      data_in.radicand = {in_data.radicand[atpr_pkg::SQ_W-3:0], 2'b00};
      if (rem_shifted >= trial) begin
         data_in.rem = atpr_pkg::REM_W'(rem_shifted - trial);
         data_in.root = {in_data.root[atpr_pkg::ROOT_W-2:0], 1'b1};
      end else begin
         data_in.rem = rem_shifted[atpr_pkg::REM_W-1:0];
         data_in.root = {in_data.root[atpr_pkg::ROOT_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data = data_ff;

endmodule

`default_nettype wire

FILE: design/atpr_cordic_cell.sv
// One vectoring micro-rotation for both the pitch and the roll vectors, registered.
// Depends on atpr_pkg for the payload type and the arctangent table.
`default_nettype none

module atpr_cordic_cell (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          advance,
   input  wire logic [atpr_pkg::STAGE_W-1:0]  stage_idx,
   input  wire logic                          in_valid,
   input  wire atpr_pkg::cordic_type          in_data,
   output      logic                          out_valid,
   output      atpr_pkg::cordic_type          out_data
);

   logic valid_ff;
   atpr_pkg::cordic_type data_ff;
   atpr_pkg::cordic_type data_in;

   function automatic atpr_pkg::rot_type rotate(input atpr_pkg::rot_type r,
                                                input logic [atpr_pkg::STAGE_W-1:0] idx);
      logic signed [atpr_pkg::VEC_W-1:0] xs;
      logic signed [atpr_pkg::VEC_W-1:0] ys;
      logic signed [atpr_pkg::ACC_W-1:0] angle;
      atpr_pkg::rot_type o;
      xs = r.vx >>> idx;
      ys = r.vy >>> idx;
      angle = atpr_pkg::atan_entry(idx);
      o = r;
      if (!r.vy[atpr_pkg::VEC_W-1]) begin
         o.vx = r.vx + ys;
         o.vy = r.vy - xs;
         o.acc = r.acc + angle;
      end else begin
         o.vx = r.vx - ys;
         o.vy = r.vy + xs;
         o.acc = r.acc - angle;
      end
      return o;
   endfunction

   always_comb begin
      data_in.pitch = rotate(in_data.pitch, stage_idx);
      data_in.roll = rotate(in_data.roll, stage_idx);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data = data_ff;

endmodule

`default_nettype wire

FILE: design/accel_tilt_pitch_roll.sv
// Tilt angles from one accelerometer sample: squares, a 30-cell square root chain,
// then a chain of CORDIC vectoring cells that turns pitch and roll together.
// Registered in order: squares, sum, square root cells, CORDIC entry, CORDIC cells, response.
// Throughput: one request per cycle; a stalled response freezes the whole pipeline.
// Reset clears only the valid bits; depends on atpr_pkg and both cell modules.
`default_nettype none

module accel_tilt_pitch_roll (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output      logic                                 req_stall,
   input  wire logic signed [atpr_pkg::AXIS_W-1:0]   req_accel_x,
   input  wire logic signed [atpr_pkg::AXIS_W-1:0]   req_accel_y,
   input  wire logic signed [atpr_pkg::AXIS_W-1:0]   req_accel_z,
   output      logic                                 rsp_valid,
   input  wire logic                                 rsp_stall,
   output      logic signed [atpr_pkg::PITCH_W-1:0]  rsp_pitch_angle,
   output      logic signed [atpr_pkg::ROLL_W-1:0]   rsp_roll_angle
);

   logic advance;

   logic sq_valid_ff;
   logic signed [atpr_pkg::AXIS_W-1:0] sq_x_ff;
   logic signed [atpr_pkg::AXIS_W-1:0] sq_y_ff;
   logic signed [atpr_pkg::AXIS_W-1:0] sq_z_ff;
   logic [atpr_pkg::SQ_W-1:0] yy_ff;
   logic [atpr_pkg::SQ_W-1:0] zz_ff;
   logic [atpr_pkg::SQ_W-1:0] yy_in;
   logic [atpr_pkg::SQ_W-1:0] zz_in;

   logic sum_valid_ff;
   atpr_pkg::sqrt_type sum_ff;
   atpr_pkg::sqrt_type sum_in;

   logic [atpr_pkg::SQRT_CELLS:0] sqrt_valid;
   atpr_pkg::sqrt_type sqrt_data [atpr_pkg::SQRT_CELLS+1];

   logic entry_valid_ff;
   atpr_pkg::cordic_type entry_ff;
   atpr_pkg::cordic_type entry_in;
   logic signed [atpr_pkg::VEC_W-1:0] x_scaled;
   logic signed [atpr_pkg::VEC_W-1:0] y_scaled;
   logic signed [atpr_pkg::VEC_W-1:0] z_scaled;

   logic [atpr_pkg::CORDIC_CELLS:0] cordic_valid;
   atpr_pkg::cordic_type cordic_data [atpr_pkg::CORDIC_CELLS+1];

   logic rsp_valid_ff;
   logic signed [atpr_pkg::PITCH_W-1:0] rsp_pitch_ff;
   logic signed [atpr_pkg::ROLL_W-1:0] rsp_roll_ff;
   logic signed [atpr_pkg::RES_W-1:0] pitch_res;
   logic signed [atpr_pkg::RES_W-1:0] roll_res;

   function automatic logic signed [atpr_pkg::RES_W-1:0] round_clamp(
      input atpr_pkg::rot_type r,
      input logic signed [atpr_pkg::RES_W-1:0] limit
   );
      logic signed [atpr_pkg::ACC_W:0] biased;
      logic signed [atpr_pkg::RES_W-1:0] q;
      logic signed [atpr_pkg::RES_W-1:0] res;
      biased = (atpr_pkg::ACC_W + 1)'(r.acc) + atpr_pkg::ROUND_BIAS;
      q = $signed(biased[atpr_pkg::ACC_W:atpr_pkg::ROUND_SHIFT]);
      priority if (r.zero) begin
         res = '0;
      end else if (q > limit) begin
         res = limit;
      end else if (q < -limit) begin
         res = -limit;
      end else begin
         res = q;
      end
      return res;
   endfunction

   assign advance = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;

   // Squares of the y and z counts.
   assign yy_in = req_accel_y * req_accel_y;
   assign zz_in = req_accel_z * req_accel_z;

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff <= 1'b0;
      end else if (advance) begin
         sq_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sq_x_ff <= req_accel_x;
         sq_y_ff <= req_accel_y;
         sq_z_ff <= req_accel_z;
         yy_ff <= yy_in;
         zz_ff <= zz_in;
      end
   end

   always_comb begin
      sum_in.radicand = yy_ff + zz_ff;
      sum_in.rem = '0;
      sum_in.root = '0;
      sum_in.accel_x = sq_x_ff;
      sum_in.accel_y = sq_y_ff;
      sum_in.accel_z = sq_z_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_valid_ff <= 1'b0;
      end else if (advance) begin
         sum_valid_ff <= sq_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sum_ff <= sum_in;
      end
   end

   assign sqrt_valid[0] = sum_valid_ff;
   assign sqrt_data[0] = sum_ff;

   for (genvar i = 0; i < atpr_pkg::SQRT_CELLS; i++) begin : g_sqrt
      atpr_sqrt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (sqrt_valid[i]),
         .in_data   (sqrt_data[i]),
         .out_valid (sqrt_valid[i+1]),
         .out_data  (sqrt_data[i+1])
      );
   end

   // Pitch vector is (y-z magnitude, -x); roll vector is (z, y), turned by
   // half a circle into the right half plane when z is negative.
   always_comb begin
      x_scaled = atpr_pkg::VEC_W'(sqrt_data[atpr_pkg::SQRT_CELLS].accel_x) <<<
                 atpr_pkg::GUARD_SHIFT;
      y_scaled = atpr_pkg::VEC_W'(sqrt_data[atpr_pkg::SQRT_CELLS].accel_y) <<<
                 atpr_pkg::GUARD_SHIFT;
      z_scaled = atpr_pkg::VEC_W'(sqrt_data[atpr_pkg::SQRT_CELLS].accel_z) <<<
                 atpr_pkg::GUARD_SHIFT;

      entry_in.pitch.vx = atpr_pkg::VEC_W'(sqrt_data[atpr_pkg::SQRT_CELLS].root);
      entry_in.pitch.vy = -x_scaled;
      entry_in.pitch.acc = '0;
      entry_in.pitch.zero = (sqrt_data[atpr_pkg::SQRT_CELLS].root == '0) &&
                            (sqrt_data[atpr_pkg::SQRT_CELLS].accel_x == '0);

      entry_in.roll.zero = (sqrt_data[atpr_pkg::SQRT_CELLS].accel_y == '0) &&
                           (sqrt_data[atpr_pkg::SQRT_CELLS].accel_z == '0);
      if (sqrt_data[atpr_pkg::SQRT_CELLS].accel_z[atpr_pkg::AXIS_W-1]) begin
         entry_in.roll.vx = -z_scaled;
         entry_in.roll.vy = -y_scaled;
         entry_in.roll.acc = sqrt_data[atpr_pkg::SQRT_CELLS].accel_y[atpr_pkg::AXIS_W-1] ?
                             -atpr_pkg::ANGLE_180 : atpr_pkg::ANGLE_180;
      end else begin
         entry_in.roll.vx = z_scaled;
         entry_in.roll.vy = y_scaled;
         entry_in.roll.acc = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= 1'b0;
      end else if (advance) begin
         entry_valid_ff <= sqrt_valid[atpr_pkg::SQRT_CELLS];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         entry_ff <= entry_in;
      end
   end

   assign cordic_valid[0] = entry_valid_ff;
   assign cordic_data[0] = entry_ff;

   for (genvar i = 0; i < atpr_pkg::CORDIC_CELLS; i++) begin : g_cordic
      atpr_cordic_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .stage_idx (atpr_pkg::STAGE_W'(i)),
         .in_valid  (cordic_valid[i]),
         .in_data   (cordic_data[i]),
         .out_valid (cordic_valid[i+1]),
         .out_data  (cordic_data[i+1])
      );
   end

   assign pitch_res = round_clamp(cordic_data[atpr_pkg::CORDIC_CELLS].pitch,
                                  atpr_pkg::PITCH_LIMIT);
   assign roll_res = round_clamp(cordic_data[atpr_pkg::CORDIC_CELLS].roll,
                                 atpr_pkg::ROLL_LIMIT);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= cordic_valid[atpr_pkg::CORDIC_CELLS];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_pitch_ff <= pitch_res[atpr_pkg::PITCH_W-1:0];
         rsp_roll_ff <= roll_res[atpr_pkg::ROLL_W-1:0];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_pitch_angle = rsp_pitch_ff;
   assign rsp_roll_angle = rsp_roll_ff;

`ifndef SYNTHESIS
   a_stall_needs_response: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("Request stalled without a pending response.");

   a_frozen_pipeline: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> ($stable(sqrt_valid) && $stable(cordic_valid)))
      else $error("Pipeline moved while the response was stalled.");

   a_pitch_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_pitch_angle <= 15'sd11520 && rsp_pitch_angle >= -15'sd11520))
      else $error("Pitch angle out of range.");

   a_roll_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_roll_angle <= 16'sd23040 && rsp_roll_angle >= -16'sd23040))
      else $error("Roll angle out of range.");
`endif

endmodule

`default_nettype wire

FILE: test/tb.sv
// Self-checking bench for accel_tilt_pitch_roll: a short directed table, then random
// accelerometer samples, checked against an in-bench CORDIC tilt model or given angles.
// Depends on atpr_pkg for the port widths and the stage count, and on the block itself.

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int AXIS_BITS = atpr_pkg::AXIS_W;
   localparam int PITCH_BITS = atpr_pkg::PITCH_W;
   localparam int ROLL_BITS = atpr_pkg::ROLL_W;
   localparam int ROT_STEPS = (atpr_pkg::CORDIC_STAGES > 24) ? 24 : atpr_pkg::CORDIC_STAGES;
   localparam longint HALF_TURN = 64'sd11796480;
   localparam longint PITCH_MAX = 64'sd11520;
   localparam longint ROLL_MAX = 64'sd23040;
   localparam int RANDOM_REQUESTS = 1600;
   localparam int DRAIN_CYCLES = 60;
   localparam int LONG_HOLD = 400;
   localparam int DIRECTED_ROWS = 20;

   typedef struct packed {
      logic signed [PITCH_BITS-1:0] pitch;
      logic signed [ROLL_BITS-1:0] roll;
   } tilt_angles_type;

   typedef struct packed {
      int x;
      int y;
      int z;
      bit known;
      int pitch;
      int roll;
   } sample_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [AXIS_BITS-1:0] req_accel_x = '0;
   logic signed [AXIS_BITS-1:0] req_accel_y = '0;
   logic signed [AXIS_BITS-1:0] req_accel_z = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [PITCH_BITS-1:0] rsp_pitch_angle;
   logic signed [ROLL_BITS-1:0] rsp_roll_angle;

   tilt_angles_type pending_angles [$];
   int mismatches = 0;
   bit gapless = 1'b0;

   longint atan_step [24] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115,
      57, 29, 14, 7, 4, 2, 1, 0
   };

   sample_row_type directed_rows [DIRECTED_ROWS] = '{
      '{0, 0, 0, 1'b1, 0, 0},
      '{0, 0, 16384, 1'b0, 0, 0},
      '{0, 0, -16384, 1'b0, 0, 0},
      '{0, -1, -16384, 1'b0, 0, 0},
      '{32767, 0, 0, 1'b0, 0, 0},
      '{-32768, 0, 0, 1'b0, 0, 0},
      '{0, 32767, 0, 1'b0, 0, 0},
      '{0, -32768, 0, 1'b0, 0, 0},
      '{0, 0, 32767, 1'b0, 0, 0},
      '{0, 0, -32768, 1'b0, 0, 0},
      '{-32768, -32768, -32768, 1'b0, 0, 0},
      '{32767, 32767, 32767, 1'b0, 0, 0},
      '{-32768, 32767, -32768, 1'b0, 0, 0},
      '{1, 0, 0, 1'b0, 0, 0},
      '{0, 1, -1, 1'b0, 0, 0},
      '{0, -1, 1, 1'b0, 0, 0},
      '{-1, -1, -1, 1'b0, 0, 0},
      '{11585, 11585, 0, 1'b0, 0, 0},
      '{0, -32768, -32768, 1'b0, 0, 0},
      '{100, -200, 16000, 1'b0, 0, 0}
   };

   accel_tilt_pitch_roll dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_accel_x(req_accel_x),
      .req_accel_y(req_accel_y),
      .req_accel_z(req_accel_z),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_pitch_angle(rsp_pitch_angle),
      .rsp_roll_angle(rsp_roll_angle)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic longint unsigned root_floor(input longint unsigned n);
      longint unsigned rem;
      longint unsigned res;
      longint unsigned b;
      rem = n;
      res = 0;
      b = 64'd1 << 62;
      while (b > rem)
         b >>= 2;
      while (b != 0) begin
         if (rem >= res + b) begin
            rem -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   function automatic longint cordic_angle(input longint num, input longint den,
                                           input longint limit);
      longint vx;
      longint vy;
      longint acc;
      longint sx;
      longint sy;
      longint r;
      vx = den;
      vy = num;
      acc = 0;
      if (vx == 0 && vy == 0)
         return 0;
      if (vx < 0) begin
         acc = (vy >= 0) ? HALF_TURN : -HALF_TURN;
         vx = -vx;
         vy = -vy;
      end
      for (int i = 0; i < ROT_STEPS; i++) begin
         sx = vx >>> i;
         sy = vy >>> i;
         if (vy >= 0) begin
            vx += sy;
            vy -= sx;
            acc += atan_step[i];
         end else begin
            vx -= sy;
            vy += sx;
            acc -= atan_step[i];
         end
      end
      r = (acc + 256) >>> 9;
      if (r > limit)
         r = limit;
      if (r < -limit)
         r = -limit;
      return r;
   endfunction

   function automatic tilt_angles_type tilt_from_sample(input longint ax, input longint ay,
                                                        input longint az);
      tilt_angles_type t;
      longint unsigned sq;
      longint mag;
      sq = ay * ay + az * az;
      mag = longint'(root_floor(sq << 28));
      t.pitch = PITCH_BITS'(cordic_angle(-ax * 16384, mag, PITCH_MAX));
      t.roll = ROLL_BITS'(cordic_angle(ay * 16384, az * 16384, ROLL_MAX));
      return t;
   endfunction

   function automatic int idle_length();
      int r;
      r = $urandom_range(99);
      if (r < 55)
         return 0;
      if (r < 88)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic int full_axis();
      return int'($urandom_range(65535)) - 32768;
   endfunction

   function automatic int edge_axis();
      unique case ($urandom_range(5))
         0: return -32768;
         1: return -32767;
         2: return -1;
         3: return 0;
         4: return 1;
         default: return 32767;
      endcase
   endfunction

   task automatic send_sample(input int x, input int y, input int z, input bit typed,
                              input tilt_angles_type typed_angles);
      int gap;
      gap = gapless ? 0 : idle_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_accel_x <= AXIS_BITS'(x);
      req_accel_y <= AXIS_BITS'(y);
      req_accel_z <= AXIS_BITS'(z);
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      pending_angles.push_back(typed ? typed_angles : tilt_from_sample(x, y, z));
   endtask

   task automatic stall_stretch();
      int r;
      int span;
      r = $urandom_range(99);
      if (r < 45) begin
         span = $urandom_range(1, 24);
         rsp_stall <= 1'b0;
      end else if (r < 85) begin
         span = $urandom_range(1, 3);
         rsp_stall <= 1'b1;
      end else if (r < 97) begin
         span = $urandom_range(4, 12);
         rsp_stall <= 1'b1;
      end else begin
         span = $urandom_range(30, 80);
         rsp_stall <= 1'b1;
      end
      repeat (span) @(posedge clock);
   endtask

   initial begin
      tilt_angles_type typed_angles;
      int kind;
      int x;
      int y;
      int z;
      int waited;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         typed_angles.pitch = PITCH_BITS'(directed_rows[i].pitch);
         typed_angles.roll = ROLL_BITS'(directed_rows[i].roll);
         send_sample(directed_rows[i].x, directed_rows[i].y, directed_rows[i].z,
                     directed_rows[i].known, typed_angles);
      end
      typed_angles = '0;
      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         if (n % 50 == 0)
            gapless = ($urandom_range(3) == 0);
         kind = $urandom_range(99);
         if (kind < 45) begin
            x = full_axis();
            y = full_axis();
            z = full_axis();
         end else if (kind < 60) begin
            x = int'($urandom_range(16)) - 8;
            y = int'($urandom_range(16)) - 8;
            z = int'($urandom_range(16)) - 8;
         end else if (kind < 72) begin
            x = edge_axis();
            y = edge_axis();
            z = edge_axis();
         end else if (kind < 84) begin
            x = $urandom_range(1) ? 0 : full_axis();
            y = $urandom_range(1) ? 0 : full_axis();
            z = $urandom_range(1) ? 0 : full_axis();
         end else begin
            x = int'($urandom_range(4000)) - 2000;
            y = int'($urandom_range(4000)) - 2000;
            z = int'($urandom_range(16000, 16800));
            if ($urandom_range(1))
               z = -z;
         end
         send_sample(x, y, z, 1'b0, typed_angles);
      end
      req_valid <= 1'b0;
      waited = 0;
      while (pending_angles.size() != 0 && waited < 100000) begin
         @(posedge clock);
         waited++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_angles.size() != 0) begin
         mismatches++;
         $display("%0t: %0d expected responses never arrived", $time, pending_angles.size());
      end
      if (mismatches == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   // The long hold lets the pipeline fill so that the block must stall new requests.
   initial begin
      int spent;
      spent = 0;
      while (reset)
         @(posedge clock);
      while (spent < 150) begin
         stall_stretch();
         spent = spent + 1;
      end
      rsp_stall <= 1'b1;
      repeat (LONG_HOLD) @(posedge clock);
      forever
         stall_stretch();
   end

   always @(posedge clock) begin : check_angles
      tilt_angles_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_angles.size() == 0) begin
            mismatches++;
            $display("%0t: response with no request outstanding, pitch %0d roll %0d",
                     $time, rsp_pitch_angle, rsp_roll_angle);
         end else begin
            want = pending_angles.pop_front();
            if (rsp_pitch_angle !== want.pitch) begin
               mismatches++;
               $display("%0t: pitch mismatch, expected %0d, actual %0d",
                        $time, want.pitch, rsp_pitch_angle);
            end
            if (rsp_roll_angle !== want.roll) begin
               mismatches++;
               $display("%0t: roll mismatch, expected %0d, actual %0d",
                        $time, want.roll, rsp_roll_angle);
            end
         end
      end
   end

   initial begin
      #10ms;
      $display("FAIL");
      $finish;
   end

endmodule

FILE: files.f
design/atpr_pkg.sv
design/atpr_sqrt_cell.sv
design/atpr_cordic_cell.sv
design/accel_tilt_pitch_roll.sv
test/tb.sv
